/* rtl/pafbf_pkg.sv */
// shared types and constants of the partition allocator
package pafbf_pkg;

   localparam int NUM_PARTS_DEF = 16;
   localparam int SIZE_BITS_DEF = 16;

   // placement rule
   localparam logic PLACE_FIRST    = 1'b0;
   localparam logic PLACE_TIGHTEST = 1'b1;

   // operation codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [1:0] STAT_NO_FIT    = 2'd1;
   localparam logic [1:0] STAT_LOAD_DONE = 2'd2;

   // register index, taken from paddr[2]
   localparam logic REG_STRATEGY = 1'b0;
   localparam logic REG_PARTS    = 1'b1;

   localparam logic [4:0] PARTS_RESET = 5'd16;

   typedef struct packed {
      logic        func;
      logic [3:0]  part_index;
      logic [15:0] capacity;
      logic [15:0] request_size;
      logic [7:0]  owner_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  granted_index;
      logic [15:0] slack;
   } rsp_payload_type;

endpackage

/* rtl/pafbf_ram.sv */
// generic single-write, single-read ram with registered read data
module pafbf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/partition_allocator_first_best_fit_top.sv */
// Fixed-partition allocator with first-fit and best-fit placement. A load item writes one
// partition's capacity into the capacity ram and frees that partition; its result is
// registered from the finish state, and the next item can be taken once the block is back
// in idle. An allocate item scans partitions 0 to partitions_in_use-1 (capped at NUM_PARTS)
// through the single ram read port and one shared subtract-and-compare unit, one partition
// per cycle; its result is registered from the finish state once the output register is
// free, and the next item can be taken once the block is back in idle. First fit stops the
// scan at the first partition that fits. The block takes one item at a time and is not ready
// during a scan, but it accepts the next item while a result still waits in the output
// register. Taken marks clear at reset; a capacity must be loaded before an allocation
// covers that partition. Registers: strategy at 0x0 (0 first fit, 1 best fit),
// partitions_in_use at 0x4.
module partition_allocator_first_best_fit_top
   import pafbf_pkg::*;
#(
   parameter int NUM_PARTS = NUM_PARTS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam int IDX_W = $clog2(NUM_PARTS);
   localparam int CNT_W = $clog2(NUM_PARTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic                  strategy_ff, strategy_in;
   logic [4:0]            parts_ff, parts_in;
   logic [NUM_PARTS-1:0]  taken_ff, taken_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  found_ff, found_in;
   logic                  is_load_ff, is_load_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]  best_slack_ff, best_slack_in;
   logic [SIZE_BITS-1:0]  req_size_ff, req_size_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_xfer;
   logic                  csr_write;
   logic [31:0]           pidx_ext;
   logic                  pidx_ok;
   logic [IDX_W-1:0]      pidx_addr;
   logic [31:0]           parts_ext;
   logic [31:0]           limit_ext;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [SIZE_BITS-1:0]  cap_rd;
   logic [SIZE_BITS:0]    diff;
   logic [SIZE_BITS-1:0]  slack;
   logic                  elig;
   logic                  hit;
   logic                  take;
   logic                  issue;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // load index may exceed the table, such loads change nothing
   assign pidx_ext  = 32'(req_data.part_index);
   assign pidx_ok   = pidx_ext < 32'(NUM_PARTS);
   assign pidx_addr = pidx_ext[IDX_W-1:0];
   assign ram_wr_en = req_xfer && (req_data.func == FUNC_LOAD) && pidx_ok;

   assign parts_ext = 32'(parts_ff);
   assign limit_ext = (parts_ext > 32'(NUM_PARTS)) ? 32'(NUM_PARTS) : parts_ext;

   // shared compare unit: slack and fit from one subtract
   assign diff  = {1'b0, cap_rd} - {1'b0, req_size_ff};
   assign slack = diff[SIZE_BITS-1:0];
   assign elig  = !taken_ff[cmp_idx_ff] && !diff[SIZE_BITS];
   assign hit   = cmp_vld_ff && elig;
   assign take  = hit && (!found_ff ||
                          ((strategy_ff == PLACE_TIGHTEST) && (slack < best_slack_ff)));

   assign issue = (state_ff == ST_SCAN) && (rd_idx_ff != limit_ff)
                  && !((strategy_ff == PLACE_FIRST) && (found_ff || hit));
   assign ram_rd_en = issue;

   pafbf_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_PARTS)
   ) u_cap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pidx_addr),
      .wr_data (SIZE_BITS'(req_data.capacity)),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (cap_rd)
   );

   always_comb begin
      case (paddr[2])
         REG_STRATEGY: prdata = {31'b0, strategy_ff};
         REG_PARTS:    prdata = {27'b0, parts_ff};
         default:      prdata = 32'b0;
      endcase
   end

   always_comb begin
      strategy_in = strategy_ff;
      parts_in    = parts_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_STRATEGY: strategy_in = pwdata[0];
            REG_PARTS:    parts_in    = pwdata[4:0];
            default:      parts_in    = parts_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      taken_in      = taken_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_data_in   = rsp_data_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      is_load_in    = is_load_ff;
      limit_in      = limit_ff;
      rd_idx_in     = rd_idx_ff;
      best_idx_in   = best_idx_ff;
      best_slack_in = best_slack_ff;
      req_size_in   = req_size_ff;

      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.func == FUNC_LOAD) begin
                  if (pidx_ok) begin
                     taken_in[pidx_addr] = 1'b0;
                  end
                  is_load_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  is_load_in  = 1'b0;
                  found_in    = 1'b0;
                  rd_idx_in   = '0;
                  limit_in    = CNT_W'(limit_ext);
                  req_size_in = SIZE_BITS'(req_data.request_size);
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in      = 1'b1;
               best_idx_in   = cmp_idx_ff;
               best_slack_in = slack;
            end
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            end else if (!cmp_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait until the output register is free
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in = 1'b1;
               if (is_load_ff) begin
                  rsp_data_in.status        = STAT_LOAD_DONE;
                  rsp_data_in.granted_index = 4'd0;
                  rsp_data_in.slack         = 16'd0;
               end else if (found_ff) begin
                  taken_in[best_idx_ff]     = 1'b1;
                  rsp_data_in.status        = STAT_ALLOCATED;
                  rsp_data_in.granted_index = 4'(best_idx_ff);
                  rsp_data_in.slack         = 16'(best_slack_ff);
               end else begin
                  rsp_data_in.status        = STAT_NO_FIT;
                  rsp_data_in.granted_index = 4'd0;
                  rsp_data_in.slack         = 16'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         strategy_ff <= PLACE_FIRST;
         parts_ff    <= PARTS_RESET;
         taken_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         strategy_ff <= strategy_in;
         parts_ff    <= parts_in;
         taken_ff    <= taken_in;
         rsp_vld_ff  <= rsp_vld_in;
         cmp_vld_ff  <= cmp_vld_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      is_load_ff    <= is_load_in;
      limit_ff      <= limit_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_slack_ff <= best_slack_in;
      req_size_ff   <= req_size_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
